// ----- rtl/c2csr_pkg.sv -----
`default_nettype none
package c2csr_pkg;

  localparam int MaxRows    = 1024;
  localparam int MaxNz      = 4096;
  localparam int RowAw      = $clog2(MaxRows);
  localparam int NzAw       = $clog2(MaxNz);
  localparam int CntW       = 13;
  localparam int ColW       = 13;
  localparam int ValW       = 32;
  localparam int InNumW     = 11;
  localparam int TripW      = RowAw + ColW + ValW;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;
  localparam logic OKIND_PTR   = 1'b0;
  localparam logic OKIND_ENTRY = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [InNumW-1:0] row_number;
    logic [InNumW-1:0] column_number;
    logic [ValW-1:0]   value_bits;
    logic              is_last;
  } in_item_t;

  typedef struct packed {
    logic            out_kind;
    logic [CntW-1:0] out_slot;
    logic [CntW-1:0] out_word;
    logic [ValW-1:0] out_value_bits;
    logic            out_last;
    logic            out_error;
  } out_item_t;

endpackage
`default_nettype wire

// ----- rtl/coo_to_csr_converter_top.sv -----
// Channel   Ports                          Transfer
// input     start, busy, in_data           start && !busy
// result    out_valid, out_data            out_valid, one cycle
// config    cfg_we, cfg_wdata              cfg_we
// A stored triple holds busy while its row count is read and rewritten; a dropped
// beat that is not the last, or an ignored beat, leaves busy low. After the last
// triple, a prefix pass over all 1024 rows, then a scatter pass over the entries,
// run one step at a time. A clearing pass after reset holds busy high.
// The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none
module coo_to_csr_converter_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire c2csr_pkg::in_item_t          in_data,
  output logic                              out_valid,
  output c2csr_pkg::out_item_t              out_data,
  input  wire logic                         cfg_we,
  input  wire logic [c2csr_pkg::InNumW-1:0] cfg_wdata
);

  logic [c2csr_pkg::InNumW-1:0] rows_r;
  logic [c2csr_pkg::InNumW-1:0] row_limit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= c2csr_pkg::InNumW'(c2csr_pkg::MaxRows);
    end else if (cfg_we) begin
      rows_r <= cfg_wdata;
    end
  end

  assign row_limit = (rows_r > c2csr_pkg::InNumW'(c2csr_pkg::MaxRows))
                     ? c2csr_pkg::InNumW'(c2csr_pkg::MaxRows) : rows_r;

  c2csr_core u_core (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .row_limit(row_limit), .out_valid(out_valid), .out_data(out_data)
  );

endmodule
`default_nettype wire

// ----- rtl/c2csr_ram.sv -----
`default_nettype none
module c2csr_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/c2csr_core.sv -----
`default_nettype none
module c2csr_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire c2csr_pkg::in_item_t          in_data,
  input  wire logic [c2csr_pkg::InNumW-1:0] row_limit,
  output logic                              out_valid,
  output c2csr_pkg::out_item_t              out_data
);

  localparam int RowAw = c2csr_pkg::RowAw;
  localparam int NzAw  = c2csr_pkg::NzAw;
  localparam int CntW  = c2csr_pkg::CntW;
  localparam int ColW  = c2csr_pkg::ColW;
  localparam int ValW  = c2csr_pkg::ValW;
  localparam int NumW  = c2csr_pkg::InNumW;
  localparam int TripW = c2csr_pkg::TripW;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_LWR   = 4'd2;
  localparam logic [3:0] S_PRD   = 4'd3;
  localparam logic [3:0] S_PWR   = 4'd4;
  localparam logic [3:0] S_SRD   = 4'd5;
  localparam logic [3:0] S_SCUR  = 4'd6;
  localparam logic [3:0] S_SWR   = 4'd7;
  localparam logic [3:0] S_DRAIN = 4'd8;
  localparam logic [3:0] S_DOUT  = 4'd9;

  localparam logic [1:0] SRC_PTR   = 2'd0;
  localparam logic [1:0] SRC_COUNT = 2'd1;
  localparam logic [1:0] SRC_ENTRY = 2'd2;

  logic [3:0]       state_r, state_nxt;
  logic [CntW-1:0]  idx_r, idx_nxt;
  logic [CntW-1:0]  acc_r, acc_nxt;
  logic [CntW-1:0]  ecount_r, ecount_nxt;
  logic [CntW-1:0]  pos_r, pos_nxt;
  logic             drop_r, drop_nxt;
  logic             last_r, last_nxt;
  logic [NumW-1:0]  jrows_r, jrows_nxt;
  logic [RowAw-1:0] lrow_r, lrow_nxt;
  logic [1:0]       src_r, src_nxt;
  logic             final_r, final_nxt;

  logic             cnt_we;
  logic [RowAw-1:0] cnt_waddr, cnt_raddr;
  logic [CntW-1:0]  cnt_wdata, cnt_rdata;
  logic             ptr_we;
  logic [CntW-1:0]  ptr_rdata;
  logic             cur_we;
  logic [RowAw-1:0] cur_waddr;
  logic [CntW-1:0]  cur_wdata, cur_rdata;
  logic             trip_we;
  logic [TripW-1:0] trip_wdata, trip_rdata;
  logic             csr_we;
  logic [ColW-1:0]  col_rdata;
  logic [ValW-1:0]  val_rdata;

  logic             acc_load, acc_drain, row_bad;
  logic [NumW-1:0]  row_m1;
  logic [CntW-1:0]  ent_pos, jrows_w;
  logic [CntW:0]    total, pos_p1;
  logic [RowAw-1:0] t_row;
  logic [ColW-1:0]  t_col;
  logic [ValW-1:0]  t_val;

  assign busy      = !(state_r == S_LOAD || state_r == S_DRAIN);
  assign acc_load  = start && !busy && state_r == S_LOAD && in_data.kind == c2csr_pkg::KIND_LOAD;
  assign acc_drain = start && !busy && state_r == S_DRAIN
                     && in_data.kind == c2csr_pkg::KIND_DRAIN;
  assign row_m1    = in_data.row_number - NumW'(1);
  assign row_bad   = in_data.row_number == '0 || in_data.row_number > row_limit;
  assign jrows_w   = CntW'(jrows_r);
  assign ent_pos   = pos_r - jrows_w - CntW'(1);
  assign total     = (CntW+1)'(jrows_w) + (CntW+1)'(ecount_r) + (CntW+1)'(1);
  assign pos_p1    = (CntW+1)'(pos_r) + (CntW+1)'(1);
  assign {t_row, t_col, t_val} = trip_rdata;

  assign trip_wdata = {row_m1[RowAw-1:0], ColW'(in_data.column_number) - ColW'(1),
                       in_data.value_bits};

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    acc_nxt    = acc_r;
    ecount_nxt = ecount_r;
    pos_nxt    = pos_r;
    drop_nxt   = drop_r;
    last_nxt   = last_r;
    jrows_nxt  = jrows_r;
    lrow_nxt   = lrow_r;
    src_nxt    = src_r;
    final_nxt  = final_r;
    cnt_we     = 1'b0;
    cnt_waddr  = idx_r[RowAw-1:0];
    cnt_wdata  = '0;
    cnt_raddr  = idx_r[RowAw-1:0];
    ptr_we     = 1'b0;
    cur_we     = 1'b0;
    cur_waddr  = idx_r[RowAw-1:0];
    cur_wdata  = acc_r;
    trip_we    = 1'b0;
    csr_we     = 1'b0;
    case (state_r)
      S_CLR: begin
        cnt_we = 1'b1;
        idx_nxt = idx_r + CntW'(1);
        if (idx_r == CntW'(c2csr_pkg::MaxRows - 1)) begin
          idx_nxt = '0;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cnt_raddr = row_m1[RowAw-1:0];
        if (acc_load) begin
          last_nxt = in_data.is_last;
          if (in_data.is_last) begin
            jrows_nxt = row_limit;
          end
          idx_nxt = '0;
          acc_nxt = '0;
          if (row_bad || ecount_r[CntW-1]) begin
            drop_nxt = 1'b1;
            if (in_data.is_last) begin
              state_nxt = S_PRD;
            end
          end else begin
            trip_we = 1'b1;
            lrow_nxt = row_m1[RowAw-1:0];
            ecount_nxt = ecount_r + CntW'(1);
            state_nxt = S_LWR;
          end
        end
      end
      S_LWR: begin
        cnt_we = 1'b1;
        cnt_waddr = lrow_r;
        cnt_wdata = cnt_rdata + CntW'(1);
        state_nxt = last_r ? S_PRD : S_LOAD;
      end
      S_PRD: begin
        state_nxt = S_PWR;
      end
      S_PWR: begin
        cnt_we = 1'b1;
        ptr_we = 1'b1;
        cur_we = 1'b1;
        acc_nxt = acc_r + cnt_rdata;
        idx_nxt = idx_r + CntW'(1);
        state_nxt = S_PRD;
        if (idx_r == CntW'(c2csr_pkg::MaxRows - 1)) begin
          idx_nxt = '0;
          state_nxt = S_SRD;
        end
      end
      S_SRD: begin
        if (idx_r == ecount_r) begin
          pos_nxt = '0;
          state_nxt = S_DRAIN;
        end else begin
          state_nxt = S_SCUR;
        end
      end
      S_SCUR: begin
        state_nxt = S_SWR;
      end
      S_SWR: begin
        csr_we = 1'b1;
        cur_we = 1'b1;
        cur_waddr = t_row;
        cur_wdata = cur_rdata + CntW'(1);
        idx_nxt = idx_r + CntW'(1);
        state_nxt = S_SRD;
      end
      S_DRAIN: begin
        if (acc_drain) begin
          final_nxt = pos_p1 >= total;
          if (pos_r < jrows_w) begin
            src_nxt = SRC_PTR;
          end else if (pos_r == jrows_w) begin
            src_nxt = SRC_COUNT;
          end else begin
            src_nxt = SRC_ENTRY;
          end
          state_nxt = S_DOUT;
        end
      end
      S_DOUT: begin
        if (final_r) begin
          pos_nxt = '0;
          ecount_nxt = '0;
          drop_nxt = 1'b0;
          state_nxt = S_LOAD;
        end else begin
          pos_nxt = pos_r + CntW'(1);
          state_nxt = S_DRAIN;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      idx_r    <= '0;
      acc_r    <= '0;
      ecount_r <= '0;
      pos_r    <= '0;
      drop_r   <= 1'b0;
      last_r   <= 1'b0;
      jrows_r  <= '0;
      src_r    <= SRC_PTR;
      final_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      acc_r    <= acc_nxt;
      ecount_r <= ecount_nxt;
      pos_r    <= pos_nxt;
      drop_r   <= drop_nxt;
      last_r   <= last_nxt;
      jrows_r  <= jrows_nxt;
      src_r    <= src_nxt;
      final_r  <= final_nxt;
    end
    lrow_r <= lrow_nxt;
  end

  c2csr_ram #(.W(CntW), .D(c2csr_pkg::MaxRows)) u_counts (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata)
  );

  c2csr_ram #(.W(CntW), .D(c2csr_pkg::MaxRows)) u_rowptr (
    .clk(clk), .we(ptr_we), .waddr(idx_r[RowAw-1:0]), .wdata(acc_r),
    .raddr(pos_r[RowAw-1:0]), .rdata(ptr_rdata)
  );

  c2csr_ram #(.W(CntW), .D(c2csr_pkg::MaxRows)) u_cursor (
    .clk(clk), .we(cur_we), .waddr(cur_waddr), .wdata(cur_wdata),
    .raddr(t_row), .rdata(cur_rdata)
  );

  c2csr_ram #(.W(TripW), .D(c2csr_pkg::MaxNz)) u_triples (
    .clk(clk), .we(trip_we), .waddr(ecount_r[NzAw-1:0]), .wdata(trip_wdata),
    .raddr(idx_r[NzAw-1:0]), .rdata(trip_rdata)
  );

  c2csr_ram #(.W(ColW), .D(c2csr_pkg::MaxNz)) u_cols (
    .clk(clk), .we(csr_we), .waddr(cur_rdata[NzAw-1:0]), .wdata(t_col),
    .raddr(ent_pos[NzAw-1:0]), .rdata(col_rdata)
  );

  c2csr_ram #(.W(ValW), .D(c2csr_pkg::MaxNz)) u_vals (
    .clk(clk), .we(csr_we), .waddr(cur_rdata[NzAw-1:0]), .wdata(t_val),
    .raddr(ent_pos[NzAw-1:0]), .rdata(val_rdata)
  );

  always_comb begin
    out_valid = state_r == S_DOUT;
    out_data.out_last  = final_r;
    out_data.out_error = drop_r;
    out_data.out_kind  = c2csr_pkg::OKIND_PTR;
    out_data.out_slot  = pos_r;
    out_data.out_word  = ptr_rdata;
    out_data.out_value_bits = '0;
    case (src_r)
      SRC_PTR: begin
        out_data.out_word = ptr_rdata;
      end
      SRC_COUNT: begin
        out_data.out_word = ecount_r;
      end
      SRC_ENTRY: begin
        out_data.out_kind = c2csr_pkg::OKIND_ENTRY;
        out_data.out_slot = CntW'(ent_pos[NzAw-1:0]);
        out_data.out_word = col_rdata;
        out_data.out_value_bits = val_rdata;
      end
      default: begin
        out_data.out_word = '0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_out_after_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(acc_drain))
    else $error("result without a drain tick");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ecount_r <= CntW'(c2csr_pkg::MaxNz))
    else $error("entry count overflow");
  a_scatter_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SWR |-> cur_rdata < ecount_r)
    else $error("scatter slot beyond entry count");
  a_busy_work: assert property (@(posedge clk) disable iff (!rst_n)
    acc_load && !in_data.is_last && !row_bad && !ecount_r[CntW-1] |=> busy ##1 !busy)
    else $error("load did not return to idle");
`endif

endmodule
`default_nettype wire
